// ===== hdl/cartesian_tree_builder_unit_defines.svh =====
// Assertion macros shared by the Cartesian tree builder.
// Depends on nothing.
`ifndef CARTESIAN_TREE_BUILDER_UNIT_DEFINES_SVH
`define CARTESIAN_TREE_BUILDER_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define CTB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/ctb_pkg.sv =====
// Types and codes shared by the Cartesian tree builder modules.
// Depends on nothing.
package ctb_pkg;
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_BAD   = 2'd2,
		ST_SPARE = 2'd3
	} status_t;

	localparam int unsigned NODE_BITS = 11;
	localparam int unsigned VALUE_BITS = 32;
endpackage

// ===== hdl/cartesian_tree_builder_unit.sv =====
// Top level of the Cartesian tree builder: command queue front and tree engine.
// Depends on ctb_pkg, ctb_front and ctb_engine.
//
// Channel  Handshake           Fields
// command  start, busy         action, value, index
// result   done strobe         status, node_number, tree_root, parent/left/right_node
//
// Clear, full append and bad query go from queue to result without leaving the idle state.
// Append reads then compares each node popped off the right spine (memory read then compare),
// then links the new node; past the root, or into an empty tree, it goes straight to the link.
// Query answers from the registered node memory read.
// Reset clears the node count and root; node memories need no clearing.
// busy rises while two commands wait in the queue; results cannot be stalled.
module cartesian_tree_builder_unit #(
	parameter int unsigned MAX_NODES = 1024,
	parameter int unsigned KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] value,
	input  logic [10:0] index,
	output logic        done,
	output logic [1:0]  status,
	output logic [10:0] node_number,
	output logic [10:0] tree_root,
	output logic [10:0] parent_node,
	output logic [10:0] left_node,
	output logic [10:0] right_node
);
	logic q_valid, q_pop;
	ctb_pkg::action_t q_action;
	logic [KEY_BITS-1:0] q_value;
	logic [10:0] q_index;

	ctb_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk, .arst_n, .start, .busy, .action, .value, .index,
		.q_valid, .q_pop, .q_action, .q_value, .q_index
	);

	ctb_engine #(.MAX_NODES(MAX_NODES), .KEY_BITS(KEY_BITS)) u_engine (
		.clk, .arst_n, .q_valid, .q_pop, .q_action, .q_value, .q_index,
		.done, .status, .node_number, .tree_root, .parent_node, .left_node, .right_node
	);
endmodule

// ===== hdl/ctb_front.sv =====
// Front end: accepts command beats and queues them for the tree engine.
// Depends on ctb_pkg.
module ctb_front #(
	parameter int unsigned KEY_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic [ctb_pkg::VALUE_BITS-1:0] value,
	input  logic [ctb_pkg::NODE_BITS-1:0]  index,
	output logic                        q_valid,
	input  logic                        q_pop,
	output ctb_pkg::action_t            q_action,
	output logic [KEY_BITS-1:0]         q_value,
	output logic [ctb_pkg::NODE_BITS-1:0]  q_index
);
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	ctb_pkg::action_t act_q [2];
	logic [KEY_BITS-1:0] val_q [2];
	logic [ctb_pkg::NODE_BITS-1:0] idx_q [2];
	logic push;
	logic [63:0] vext;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_action = act_q[rp_q];
	assign q_value = val_q[rp_q];
	assign q_index = idx_q[rp_q];
	assign vext = {{(64-ctb_pkg::VALUE_BITS){1'b0}}, value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			act_q[wp_q] <= ctb_pkg::action_t'(action);
			val_q[wp_q] <= vext[KEY_BITS-1:0];
			idx_q[wp_q] <= index;
		end
	end
endmodule

// ===== hdl/ctb_engine.sv =====
// Back end: walks the right spine in node memories and answers commands.
// Depends on ctb_pkg and the assertion macro header.
`include "cartesian_tree_builder_unit_defines.svh"
module ctb_engine #(
	parameter int unsigned MAX_NODES = 1024,
	parameter int unsigned KEY_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  ctb_pkg::action_t           q_action,
	input  logic [KEY_BITS-1:0]        q_value,
	input  logic [ctb_pkg::NODE_BITS-1:0] q_index,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [ctb_pkg::NODE_BITS-1:0] node_number,
	output logic [ctb_pkg::NODE_BITS-1:0] tree_root,
	output logic [ctb_pkg::NODE_BITS-1:0] parent_node,
	output logic [ctb_pkg::NODE_BITS-1:0] left_node,
	output logic [ctb_pkg::NODE_BITS-1:0] right_node
);
	localparam int unsigned AW = $clog2(MAX_NODES);
	localparam int unsigned NB = ctb_pkg::NODE_BITS;
	localparam int unsigned CW = $clog2(MAX_NODES + 1);
	typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_LINK, S_QRD, S_QOUT} state_t;

	logic [KEY_BITS-1:0] key_mem [MAX_NODES];
	logic [CW-1:0] par_mem [MAX_NODES];
	logic [CW-1:0] lft_mem [MAX_NODES];
	logic [CW-1:0] rgt_mem [MAX_NODES];

	state_t state_q;
	logic [CW-1:0] count_q, root_q, k_q, qi_q;
	logic [KEY_BITS-1:0] val_q, key_rd_q;
	logic [CW-1:0] par_rd_q, lft_rd_q, rgt_rd_q;
	logic [AW-1:0] ra;
	logic idle_pop;
	logic [CW-1:0] new_n;

	assign idle_pop = (state_q == S_IDLE) && q_valid;
	assign q_pop = idle_pop;
	assign new_n = count_q + CW'(1);
	assign ra = (state_q == S_QRD) ? AW'(qi_q - CW'(1)) : AW'(k_q - CW'(1));

	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[ra];
		par_rd_q <= par_mem[ra];
		lft_rd_q <= lft_mem[ra];
		rgt_rd_q <= rgt_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			root_q <= '0;
			k_q <= '0;
			qi_q <= '0;
			val_q <= '0;
			done <= 1'b0;
			status <= '0;
			node_number <= '0;
			tree_root <= '0;
			parent_node <= '0;
			left_node <= '0;
			right_node <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						parent_node <= '0;
						left_node <= '0;
						right_node <= '0;
						node_number <= '0;
						status <= ctb_pkg::ST_OK;
						tree_root <= NB'(root_q);
						case (q_action)
							ctb_pkg::ACT_CLEAR: begin
								count_q <= '0;
								root_q <= '0;
								tree_root <= '0;
								done <= 1'b1;
							end
							ctb_pkg::ACT_APPEND: begin
								if (count_q >= CW'(MAX_NODES)) begin
									status <= ctb_pkg::ST_FULL;
									done <= 1'b1;
								end else begin
									val_q <= q_value;
									k_q <= count_q;
									state_q <= (count_q == '0) ? S_LINK : S_RD;
								end
							end
							ctb_pkg::ACT_QUERY: begin
								if (q_index == '0 || {1'b0, q_index} > (NB+1)'(count_q)) begin
									status <= ctb_pkg::ST_BAD;
									done <= 1'b1;
								end else begin
									qi_q <= CW'(q_index);
									state_q <= S_QRD;
								end
							end
							default: done <= 1'b1;
						endcase
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (key_rd_q > val_q) begin
						k_q <= par_rd_q;
						state_q <= (par_rd_q == '0) ? S_LINK : S_RD;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (k_q == '0) begin
						root_q <= new_n;
						left_node <= NB'(root_q);
						tree_root <= NB'(new_n);
					end else begin
						left_node <= NB'(rgt_rd_q);
					end
					count_q <= new_n;
					node_number <= NB'(new_n);
					parent_node <= NB'(k_q);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				S_QRD: state_q <= S_QOUT;
				S_QOUT: begin
					node_number <= NB'(qi_q);
					parent_node <= NB'(par_rd_q);
					left_node <= NB'(lft_rd_q);
					right_node <= NB'(rgt_rd_q);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [CW-1:0] lnk;
	assign lnk = (k_q == '0) ? root_q : rgt_rd_q;

	always_ff @(posedge clk) begin
		if (state_q == S_LINK) begin
			key_mem[AW'(count_q)] <= val_q;
			par_mem[AW'(count_q)] <= k_q;
			lft_mem[AW'(count_q)] <= lnk;
			rgt_mem[AW'(count_q)] <= '0;
			if (k_q != '0) rgt_mem[AW'(k_q - CW'(1))] <= new_n;
			if (lnk != '0) par_mem[AW'(lnk - CW'(1))] <= new_n;
		end
	end

	`CTB_ASSERT_IMPL(a_count_max, 1'b1, count_q <= CW'(MAX_NODES), "node count overflow")
	`CTB_ASSERT_IMPL(a_pop_idle, q_pop, state_q == S_IDLE, "pop outside idle")
	`CTB_ASSERT_NEXT(a_link_done, state_q == S_LINK, done && status == ctb_pkg::ST_OK,
		"append finished without result")
	`CTB_ASSERT_IMPL(a_root_range, 1'b1, root_q <= count_q, "root beyond count")
endmodule

// ===== tb/cartesian_tree_builder_unit_test.sv =====
// Self-checking testbench for cartesian_tree_builder_unit: directed table, then random commands.
// Expected results come from a local model of the right-spine tree build.
// Depends on ctb_pkg and the cartesian_tree_builder_unit RTL.
module cartesian_tree_builder_unit_test;
	localparam int unsigned NODE_LIMIT = 1024;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] node_number;
		logic [10:0] tree_root;
		logic [10:0] parent_node;
		logic [10:0] left_node;
		logic [10:0] right_node;
	} tree_answer_t;

	typedef struct {
		ctb_pkg::action_t act;
		logic [31:0] key;
		logic [10:0] idx;
		bit          typed;
		tree_answer_t answer;
	} command_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [31:0] value;
	logic [10:0] index;
	logic        done;
	logic [1:0]  status;
	logic [10:0] node_number;
	logic [10:0] tree_root;
	logic [10:0] parent_node;
	logic [10:0] left_node;
	logic [10:0] right_node;

	cartesian_tree_builder_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .value(value), .index(index), .done(done),
		.status(status), .node_number(node_number), .tree_root(tree_root),
		.parent_node(parent_node), .left_node(left_node), .right_node(right_node)
	);

	logic [31:0] model_key [1:NODE_LIMIT];
	logic [10:0] model_parent [1:NODE_LIMIT];
	logic [10:0] model_left [1:NODE_LIMIT];
	logic [10:0] model_right [1:NODE_LIMIT];
	int unsigned model_count;
	logic [10:0] model_root;

	tree_answer_t pending_answers[$];
	int errors;
	int beats_in;
	int beats_out;
	int idle_cycles;
	int send_gap_pct;

	function automatic tree_answer_t tree_step(ctb_pkg::action_t act, logic [31:0] key,
			logic [10:0] idx);
		tree_answer_t a;
		int unsigned k;
		int unsigned n;
		logic [10:0] lft;
		a = '0;
		case (act)
			ctb_pkg::ACT_CLEAR: begin
				model_count = 0;
				model_root = 0;
			end
			ctb_pkg::ACT_APPEND: begin
				if (model_count >= NODE_LIMIT) begin
					a.status = ctb_pkg::ST_FULL;
				end else begin
					n = model_count + 1;
					k = model_count;
					while (k != 0 && model_key[k] > key)
						k = model_parent[k];
					if (k == 0) begin
						lft = model_root;
						model_root = n[10:0];
					end else begin
						lft = model_right[k];
						model_right[k] = n[10:0];
					end
					model_key[n] = key;
					model_parent[n] = k[10:0];
					model_left[n] = lft;
					model_right[n] = 0;
					if (lft != 0)
						model_parent[lft] = n[10:0];
					model_count = n;
					a.node_number = n[10:0];
					a.parent_node = k[10:0];
					a.left_node = lft;
				end
			end
			ctb_pkg::ACT_QUERY: begin
				if (idx == 0 || idx > model_count) begin
					a.status = ctb_pkg::ST_BAD;
				end else begin
					a.node_number = idx;
					a.parent_node = model_parent[idx];
					a.left_node = model_left[idx];
					a.right_node = model_right[idx];
				end
			end
			default: ;
		endcase
		a.tree_root = model_root;
		return a;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		tree_answer_t exp_a;
		if (done) begin
			beats_out <= beats_out + 1;
			if (pending_answers.size() == 0) begin
				$error("result beat with no expectation waiting");
				errors++;
			end else begin
				exp_a = pending_answers.pop_front();
				if (status !== exp_a.status) begin
					$error("status expected %0d actual %0d", exp_a.status, status);
					errors++;
				end
				if (node_number !== exp_a.node_number) begin
					$error("node_number expected %0d actual %0d", exp_a.node_number, node_number);
					errors++;
				end
				if (tree_root !== exp_a.tree_root) begin
					$error("tree_root expected %0d actual %0d", exp_a.tree_root, tree_root);
					errors++;
				end
				if (parent_node !== exp_a.parent_node) begin
					$error("parent_node expected %0d actual %0d", exp_a.parent_node, parent_node);
					errors++;
				end
				if (left_node !== exp_a.left_node) begin
					$error("left_node expected %0d actual %0d", exp_a.left_node, left_node);
					errors++;
				end
				if (right_node !== exp_a.right_node) begin
					$error("right_node expected %0d actual %0d", exp_a.right_node, right_node);
					errors++;
				end
			end
		end
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_command(ctb_pkg::action_t act, logic [31:0] key, logic [10:0] idx,
			bit typed, tree_answer_t answer);
		tree_answer_t predicted;
		while (($urandom_range(99) < send_gap_pct)) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		value <= key;
		index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = tree_step(act, key, idx);
		if (typed && predicted !== answer) begin
			$error("table row expected %h predictor %h", answer, predicted);
			errors++;
		end
		pending_answers.push_back(predicted);
		beats_in++;
	endtask

	task automatic send_random(int unsigned fill_pct);
		int unsigned r;
		ctb_pkg::action_t act;
		logic [31:0] key;
		logic [10:0] idx;
		r = $urandom_range(99);
		if (r < 2)
			act = ctb_pkg::ACT_CLEAR;
		else if (r < 4)
			act = ctb_pkg::ACT_NONE;
		else if (r < 4 + fill_pct)
			act = ctb_pkg::ACT_APPEND;
		else
			act = ctb_pkg::ACT_QUERY;
		case ($urandom_range(3))
			0: key = $urandom_range(15);
			1: key = $urandom;
			2: key = 32'hFFFF_FFFF - $urandom_range(3);
			default: key = $urandom_range(1000);
		endcase
		if ($urandom_range(9) == 0)
			idx = 11'($urandom);
		else
			idx = 11'($urandom_range(model_count + 1));
		send_command(act, key, idx, 1'b0, '0);
	endtask

	command_row_t table_rows[$];

	function automatic command_row_t row(ctb_pkg::action_t act, logic [31:0] key,
			logic [10:0] idx, bit typed, tree_answer_t answer);
		command_row_t r;
		r.act = act;
		r.key = key;
		r.idx = idx;
		r.typed = typed;
		r.answer = answer;
		return r;
	endfunction

	initial begin
		int drain;
		arst_n = 1'b0;
		start = 1'b0;
		action = ctb_pkg::ACT_CLEAR;
		value = '0;
		index = '0;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		send_gap_pct = 0;
		model_count = 0;
		model_root = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'd0, 1'b1,
			{ctb_pkg::ST_BAD, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0}));
		table_rows.push_back(row(ctb_pkg::ACT_NONE, 32'hFFFF_FFFF, 11'h7FF, 1'b1, '0));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'd5, 11'd0, 1'b1,
			{ctb_pkg::ST_OK, 11'd1, 11'd1, 11'd0, 11'd0, 11'd0}));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'hFFFF_FFFF, 11'h7FF, 1'b1,
			{ctb_pkg::ST_OK, 11'd2, 11'd1, 11'd1, 11'd0, 11'd0}));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'd5, 11'd0, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'd0, 11'd0, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'd7, 11'd0, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'd0, 11'd0, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'hFFFF_FFFF, 11'd1, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'd3, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'd6, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'd7, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'h7FF, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_NONE, 32'h0, 11'd1, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 11'h7FF, 1'b1, '0));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'd1, 1'b1,
			{ctb_pkg::ST_BAD, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0}));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'h8000_0000, 11'd0, 1'b1,
			{ctb_pkg::ST_OK, 11'd1, 11'd1, 11'd0, 11'd0, 11'd0}));
		table_rows.push_back(row(ctb_pkg::ACT_APPEND, 32'h7FFF_FFFF, 11'd0, 1'b1,
			{ctb_pkg::ST_OK, 11'd2, 11'd2, 11'd0, 11'd1, 11'd0}));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'd1, 1'b0, '0));
		table_rows.push_back(row(ctb_pkg::ACT_QUERY, 32'h0, 11'd2, 1'b0, '0));
		foreach (table_rows[i])
			send_command(table_rows[i].act, table_rows[i].key, table_rows[i].idx,
				table_rows[i].typed, table_rows[i].answer);

		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 11 : (phase == 1) ? 83 : 0;
			for (int i = 0; i < 227; i++)
				send_random(phase == 1 ? 30 : 50);
		end
		start <= 1'b0;

		drain = 0;
		while (pending_answers.size() != 0 && drain < WATCHDOG_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (4200) @(posedge clk);
		if (pending_answers.size() != 0) begin
			$error("%0d expected results never arrived", pending_answers.size());
			errors++;
		end
		$display("Sent %0d command beats and checked %0d result beats, directed and random.",
			beats_in, beats_out);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
